[sv/assert_macros.svh]
// assertion helpers for the cut vertex search
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every clock edge out of reset
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

[sv/apf_pkg.sv]
`default_nettype none
package apf_pkg;
    localparam int MAX_VERTICES_DEF = 16;
    localparam int ROW_W = 16;
    localparam int CNT_W = 5;
    localparam int VTX_W = 4;
    localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;
    localparam logic [0:0] REG_IGNORE_ISOLATED = 1'b1;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_ROOT,
        ST_SCAN,
        ST_POP,
        ST_CUTV,
        ST_CUTW,
        ST_ISO,
        ST_ISOW,
        ST_EMIT
    } state_t;
endpackage
`default_nettype wire

[sv/apf_ram.sv]
`default_nettype none
module apf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[sv/articulation_point_finder.sv]
// articulation_point_finder: takes vertex_count adjacency rows, one per request (bit w of
// row v is an edge v->w, rows are used as given, not symmetrized), then runs an iterative
// depth-first search with an explicit stack and gives one result per vertex in index order,
// with cut flag, cut count and component count. While a graph is searched and its results
// go out, stall stays high. Rows are taken one per cycle while stall is low; the search
// walks one matrix entry per cycle from a single registered row memory read, apart from a
// wait for each new row read. Work covers the search scan and the child scan, plus stack
// turns, root checks and the column pass, with one more pass over the rows when
// ignore_isolated is set, and the results go out one per vertex while out_stall is low.
`default_nettype none
`include "assert_macros.svh"
module articulation_point_finder #(
    parameter int MAX_VERTICES = apf_pkg::MAX_VERTICES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [4:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [15:0] row_bits,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       vertex,
    output logic             is_cut,
    output logic [4:0]       cut_total,
    output logic [4:0]       component_total,
    output logic             last
);
    localparam int LIM = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
    localparam int NP = 31;

    apf_pkg::state_t state_reg, state_next;
    logic [4:0]  vcount_reg;
    logic        ignore_reg;
    logic [4:0]  n_act;
    logic [4:0]  row_reg, row_next;
    logic [15:0] visited_reg, visited_next;
    logic [15:0] cut_reg, cut_next;
    logic [4:0]  parent_reg [16];
    logic [4:0]  disc_reg [16];
    logic [4:0]  low_reg [16];
    logic [3:0]  stv_reg [16];
    logic [4:0]  stn_reg [16];
    logic [4:0]  sp_reg, sp_next;
    logic [4:0]  time_reg, time_next;
    logic [4:0]  root_reg, root_next;
    logic [4:0]  v_reg, v_next;
    logic [4:0]  w_reg, w_next;
    logic [4:0]  kids_reg, kids_next;
    logic        flag_reg, flag_next;
    logic        wait_reg, wait_next;
    logic [4:0]  cuts_reg, cuts_next;
    logic [4:0]  comps_reg, comps_next;
    logic [15:0] colmask_reg, colmask_next;

    logic        ram_we;
    logic [3:0]  ram_waddr, ram_raddr;
    logic [15:0] ram_rdata;

    // stack side effects decided in the comb block
    logic        do_open, do_pop, do_adv, do_back;
    logic [3:0]  open_v;
    logic [3:0]  top_v;
    logic [3:0]  cur_v;
    logic [4:0]  cur_w;

    apf_ram #(.WIDTH(16), .DEPTH(16)) u_adj (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (row_bits),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        n_act = vcount_reg;
        if (n_act < 5'd1)
        begin
            n_act = 5'd1;
        end
        if (n_act > 5'(LIM))
        begin
            n_act = 5'(LIM);
        end
    end

    assign in_stall = (state_reg != apf_pkg::ST_LOAD);
    assign ram_we = in_valid && !in_stall;
    assign ram_waddr = row_reg[3:0];
    assign top_v = stv_reg[sp_reg[3:0] - 4'd1];
    assign cur_w = stn_reg[sp_reg[3:0] - 4'd1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= 5'd16;
            ignore_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                apf_pkg::REG_VERTEX_COUNT:    vcount_reg <= cfg_data;
                apf_pkg::REG_IGNORE_ISOLATED: ignore_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next = row_reg;
        visited_next = visited_reg;
        cut_next = cut_reg;
        sp_next = sp_reg;
        time_next = time_reg;
        root_next = root_reg;
        v_next = v_reg;
        w_next = w_reg;
        kids_next = kids_reg;
        flag_next = flag_reg;
        wait_next = 1'b0;
        cuts_next = cuts_reg;
        comps_next = comps_reg;
        colmask_next = colmask_reg;
        do_open = 1'b0;
        do_pop = 1'b0;
        do_adv = 1'b0;
        do_back = 1'b0;
        open_v = 4'd0;
        cur_v = top_v;
        ram_raddr = top_v;
        out_valid = 1'b0;
        case (state_reg)
            apf_pkg::ST_LOAD:
            begin
                if (in_valid)
                begin
                    row_next = row_reg + 5'd1;
                    if (row_reg + 5'd1 >= n_act)
                    begin
                        row_next = 5'd0;
                        state_next = apf_pkg::ST_INIT;
                    end
                end
            end
            apf_pkg::ST_INIT:
            begin
                visited_next = '0;
                cut_next = '0;
                sp_next = '0;
                time_next = '0;
                root_next = '0;
                cuts_next = '0;
                comps_next = '0;
                state_next = apf_pkg::ST_ROOT;
            end
            apf_pkg::ST_ROOT:
            begin
                if (root_reg >= n_act)
                begin
                    v_next = '0;
                    w_next = '0;
                    kids_next = '0;
                    flag_next = 1'b0;
                    wait_next = 1'b1;
                    state_next = apf_pkg::ST_CUTW;
                end
                else if (visited_reg[root_reg[3:0]])
                begin
                    root_next = root_reg + 5'd1;
                end
                else
                begin
                    do_open = 1'b1;
                    open_v = root_reg[3:0];
                    visited_next[root_reg[3:0]] = 1'b1;
                    time_next = time_reg + 5'd1;
                    sp_next = sp_reg + 5'd1;
                    comps_next = comps_reg + 5'd1;
                    root_next = root_reg + 5'd1;
                    wait_next = 1'b1;
                    state_next = apf_pkg::ST_SCAN;
                end
            end
            apf_pkg::ST_SCAN:
            begin
                // row of the stack top is read in the cycle before its bits are used
                if (wait_reg)
                begin
                    wait_next = 1'b0;
                end
                else if (cur_w >= n_act)
                begin
                    do_pop = 1'b1;
                    sp_next = sp_reg - 5'd1;
                    wait_next = 1'b1;
                    state_next = (sp_reg == 5'd1) ? apf_pkg::ST_ROOT : apf_pkg::ST_SCAN;
                end
                else
                begin
                    do_adv = 1'b1;
                    if (ram_rdata[cur_w[3:0]])
                    begin
                        if (!visited_reg[cur_w[3:0]])
                        begin
                            do_open = 1'b1;
                            open_v = cur_w[3:0];
                            visited_next[cur_w[3:0]] = 1'b1;
                            time_next = time_reg + 5'd1;
                            if (sp_reg < 5'd16)
                            begin
                                sp_next = sp_reg + 5'd1;
                            end
                            wait_next = 1'b1;
                        end
                        else if (cur_w != parent_reg[top_v])
                        begin
                            do_back = 1'b1;
                        end
                    end
                end
            end
            apf_pkg::ST_CUTW:
            begin
                cur_v = v_reg[3:0];
                ram_raddr = v_reg[3:0];
                if (wait_reg)
                begin
                    wait_next = 1'b0;
                end
                else if (w_reg >= n_act)
                begin
                    if (parent_reg[v_reg[3:0]] == 5'(NP))
                    begin
                        if (kids_reg > 5'd1)
                        begin
                            cut_next[v_reg[3:0]] = 1'b1;
                            cuts_next = cuts_reg + 5'd1;
                        end
                    end
                    else if (flag_reg)
                    begin
                        cut_next[v_reg[3:0]] = 1'b1;
                        cuts_next = cuts_reg + 5'd1;
                    end
                    v_next = v_reg + 5'd1;
                    w_next = '0;
                    kids_next = '0;
                    flag_next = 1'b0;
                    wait_next = 1'b1;
                    if (v_reg + 5'd1 >= n_act)
                    begin
                        v_next = '0;
                        colmask_next = '0;
                        state_next = apf_pkg::ST_ISOW;
                    end
                end
                else
                begin
                    if (parent_reg[w_reg[3:0]] == v_reg && ram_rdata[w_reg[3:0]])
                    begin
                        kids_next = kids_reg + 5'd1;
                        if (low_reg[w_reg[3:0]] >= disc_reg[v_reg[3:0]])
                        begin
                            flag_next = 1'b1;
                        end
                    end
                    w_next = w_reg + 5'd1;
                end
            end
            apf_pkg::ST_ISOW:
            begin
                // pass one: gather column bits over all rows
                ram_raddr = v_reg[3:0];
                if (wait_reg)
                begin
                    wait_next = 1'b0;
                end
                else
                begin
                    colmask_next = colmask_reg | ram_rdata;
                    v_next = v_reg + 5'd1;
                    wait_next = 1'b1;
                    if (v_reg + 5'd1 >= n_act)
                    begin
                        v_next = '0;
                        state_next = ignore_reg ? apf_pkg::ST_ISO : apf_pkg::ST_EMIT;
                    end
                end
            end
            apf_pkg::ST_ISO:
            begin
                ram_raddr = v_reg[3:0];
                if (wait_reg)
                begin
                    wait_next = 1'b0;
                end
                else
                begin
                    if (((ram_rdata & ((16'd1 << n_act) - 16'd1)) == '0)
                        && !colmask_reg[v_reg[3:0]] && comps_reg != '0)
                    begin
                        comps_next = comps_reg - 5'd1;
                    end
                    v_next = v_reg + 5'd1;
                    wait_next = 1'b1;
                    if (v_reg + 5'd1 >= n_act)
                    begin
                        v_next = '0;
                        state_next = apf_pkg::ST_EMIT;
                    end
                end
            end
            apf_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    v_next = v_reg + 5'd1;
                    if (v_reg + 5'd1 >= n_act)
                    begin
                        state_next = apf_pkg::ST_LOAD;
                    end
                end
            end
            default: state_next = apf_pkg::ST_LOAD;
        endcase
    end

    // column mask must only see active columns
    logic [15:0] nmask;
    assign nmask = (16'd1 << n_act) - 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= apf_pkg::ST_LOAD;
            row_reg <= '0;
            visited_reg <= '0;
            cut_reg <= '0;
            sp_reg <= '0;
            time_reg <= '0;
            root_reg <= '0;
            v_reg <= '0;
            w_reg <= '0;
            kids_reg <= '0;
            flag_reg <= 1'b0;
            wait_reg <= 1'b0;
            cuts_reg <= '0;
            comps_reg <= '0;
            colmask_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg <= (cfg_we && cfg_index == apf_pkg::REG_VERTEX_COUNT) ? 5'd0 : row_next;
            visited_reg <= visited_next;
            cut_reg <= cut_next;
            sp_reg <= sp_next;
            time_reg <= time_next;
            root_reg <= root_next;
            v_reg <= v_next;
            w_reg <= w_next;
            kids_reg <= kids_next;
            flag_reg <= flag_next;
            wait_reg <= wait_next;
            cuts_reg <= cuts_next;
            comps_reg <= comps_next;
            colmask_reg <= colmask_next & nmask;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == apf_pkg::ST_INIT)
        begin
            for (int i = 0; i < 16; i++)
            begin
                parent_reg[i] <= 5'(NP);
                disc_reg[i] <= '0;
                low_reg[i] <= '0;
            end
        end
        else
        begin
            if (do_adv)
            begin
                stn_reg[sp_reg[3:0] - 4'd1] <= cur_w + 5'd1;
            end
            if (do_open)
            begin
                disc_reg[open_v] <= time_reg + 5'd1;
                low_reg[open_v] <= time_reg + 5'd1;
                if (state_reg == apf_pkg::ST_SCAN)
                begin
                    parent_reg[open_v] <= {1'b0, cur_v};
                end
                if (sp_reg < 5'd16)
                begin
                    stv_reg[sp_reg[3:0]] <= open_v;
                    stn_reg[sp_reg[3:0]] <= '0;
                end
            end
            if (do_back && disc_reg[cur_w[3:0]] < low_reg[top_v])
            begin
                low_reg[top_v] <= disc_reg[cur_w[3:0]];
            end
            if (do_pop && sp_reg > 5'd1)
            begin
                if (low_reg[top_v] < low_reg[stv_reg[sp_reg[3:0] - 4'd2]])
                begin
                    low_reg[stv_reg[sp_reg[3:0] - 4'd2]] <= low_reg[top_v];
                end
            end
        end
    end

    assign vertex = v_reg[3:0];
    assign is_cut = cut_reg[v_reg[3:0]];
    assign cut_total = cuts_reg;
    assign component_total = comps_reg;
    assign last = (v_reg + 5'd1 == n_act);

    `ASSERT_IMP(a_stall_busy, out_valid, in_stall, "input taken while results pending")
    `ASSERT_CLK(a_sp_range, sp_reg <= 5'd16, "search stack overflow")
    `ASSERT_IMP(a_cut_count, out_valid, $countones(cut_reg) == cuts_reg, "cut count mismatch")
    `ASSERT_IMP(a_last_once, out_valid && last && !out_stall, ##1 !out_valid,
        "results continue after last")
endmodule
`default_nettype wire
